### src/ocws_pkg.sv
// ocws_pkg: shared types, constants and the sine function for the wheel speed block
// no dependencies

package ocws_pkg;

	localparam logic [1:0] REG_BASE_MODE = 2'd0;
	localparam logic [1:0] REG_RADIUS    = 2'd1;
	localparam logic [1:0] REG_ARM       = 2'd2;
	localparam logic [1:0] REG_SCALE     = 2'd3;

	localparam logic [15:0] ANG30   = 16'd5461;
	localparam logic [15:0] ANG60   = 16'd10923;
	localparam logic [15:0] QUARTER = 16'd16384;

	typedef logic [15:0] sine_tab_t [0:64];

	localparam sine_tab_t QUARTER_SINE = '{
		16'd0, 16'd402, 16'd804, 16'd1205, 16'd1606, 16'd2006, 16'd2404, 16'd2801,
		16'd3196, 16'd3590, 16'd3981, 16'd4370, 16'd4756, 16'd5139, 16'd5520, 16'd5897,
		16'd6270, 16'd6639, 16'd7005, 16'd7366, 16'd7723, 16'd8076, 16'd8423, 16'd8765,
		16'd9102, 16'd9434, 16'd9760, 16'd10080, 16'd10394, 16'd10702, 16'd11003,
		16'd11297, 16'd11585, 16'd11866, 16'd12140, 16'd12406, 16'd12665, 16'd12916,
		16'd13160, 16'd13395, 16'd13623, 16'd13842, 16'd14053, 16'd14256, 16'd14449,
		16'd14635, 16'd14811, 16'd14978, 16'd15137, 16'd15286, 16'd15426, 16'd15557,
		16'd15679, 16'd15791, 16'd15893, 16'd15986, 16'd16069, 16'd16143, 16'd16207,
		16'd16261, 16'd16305, 16'd16340, 16'd16364, 16'd16379, 16'd16384
	};

	typedef struct packed {
		logic       mode;
		logic [11:0] radius;
		logic [15:0] arm;
		logic [31:0] scale;
	} cfg_t;

	// sine in q1.14, 16 bit signed result covers -16384..16384
	function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
		logic [14:0] p;
		logic [6:0]  i;
		logic [7:0]  f;
		logic [15:0] t0;
		logic [15:0] t1;
		logic [23:0] prod;
		logic [15:0] val;
		p = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
		i = p[14:8];
		f = p[7:0];
		if (i[6]) begin
			val = QUARTER;
		end else begin
			t0 = QUARTER_SINE[i[5:0]];
			t1 = QUARTER_SINE[i[5:0] + 6'd1 == 6'd0 ? 7'd64 : {1'b0, i[5:0] + 6'd1}];
			prod = (t1 - t0) * f + 24'd128;
			val = t0 + prod[23:8];
		end
		return a[15] ? -$signed(val) : $signed(val);
	endfunction

endpackage

### src/ocws_trig.sv
// ocws_trig: stage 1, registered sine and cosine lookups for the three angles
// depends on ocws_pkg

module ocws_trig import ocws_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld_in,
	input  logic [15:0]         heading,
	output logic                vld_s1,
	output logic signed [15:0]  cos0_s1,
	output logic signed [15:0]  sin0_s1,
	output logic signed [15:0]  cos30_s1,
	output logic signed [15:0]  sin30_s1,
	output logic signed [15:0]  cos60_s1,
	output logic signed [15:0]  sin60_s1
);

	logic [15:0] h30;
	logic [15:0] h60;
	assign h30 = heading + ANG30;
	assign h60 = heading + ANG60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		cos0_s1  <= sine_q14(heading + QUARTER);
		sin0_s1  <= sine_q14(heading);
		cos30_s1 <= sine_q14(h30 + QUARTER);
		sin30_s1 <= sine_q14(h30);
		cos60_s1 <= sine_q14(h60 + QUARTER);
		sin60_s1 <= sine_q14(h60);
	end

endmodule

### src/ocws_pulse.sv
// ocws_pulse: scales one q18 velocity by the q16.16 pulse factor and saturates
// two register stages; depends on ocws_pkg

module ocws_pulse import ocws_pkg::*; #(
	parameter int SPEED_WIDTH = 25
) (
	input  logic                          clk,
	input  logic signed [39:0]            vel,
	input  logic [31:0]                   scale,
	output logic signed [SPEED_WIDTH-1:0] speed,
	output logic                          sat
);

	localparam logic [56:0] MAXPOS = 57'((64'd1 << (SPEED_WIDTH - 1)) - 64'd1);

	logic        neg_a;
	logic [39:0] mag;
	logic [55:0] phi_a;
	logic [55:0] plo_a;
	logic        neg_b;
	logic [56:0] m_b;
	logic [56:0] sum;
	logic [56:0] mclamp;
	logic [SPEED_WIDTH-1:0] fld;

	assign mag = vel[39] ? 40'(-vel) : 40'(vel);

	always_ff @(posedge clk) begin
		neg_a <= vel[39];
		phi_a <= mag * scale[31:16];
		plo_a <= mag * scale[15:0];
	end

	assign sum = {1'b0, phi_a} + {17'd0, plo_a[55:16]};

	always_ff @(posedge clk) begin
		neg_b <= neg_a;
		m_b   <= {18'd0, sum[56:18]};
	end

	always_comb begin
		sat = 1'b0;
		mclamp = m_b;
		if (!neg_b && m_b > MAXPOS) begin
			mclamp = MAXPOS;
			sat = 1'b1;
		end else if (neg_b && m_b > MAXPOS + 57'd1) begin
			mclamp = MAXPOS + 57'd1;
			sat = 1'b1;
		end
		fld = neg_b ? SPEED_WIDTH'(-mclamp) : mclamp[SPEED_WIDTH-1:0];
		speed = $signed(fld);
	end

endmodule

### src/omni_chassis_wheel_speeds.sv
// omni_chassis_wheel_speeds: top level of the wheel speed pipeline
// depends on ocws_pkg, ocws_trig, ocws_pulse
//
// channel   direction  handshake            payload
// command   in         start / busy         vel_x vel_y omega heading
// config    in         cfg_valid/cfg_ready  cfg_index cfg_data
// result    out        done strobe          wheel_a..d_speed saturated
//
// one item per cycle; done is the valid bit that leaves the last of the stages below
// stages: trig lookup, products, wheel sums, pulse multiply, scale and clamp
// busy is held low: the receiver cannot stall so nothing ever backs up
// reset clears the valid bits and loads the register defaults

module omni_chassis_wheel_speeds import ocws_pkg::*; #(
	parameter int SPEED_WIDTH = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [15:0]            vel_x,
	input  logic signed [15:0]            vel_y,
	input  logic signed [15:0]            omega,
	input  logic [15:0]                   heading,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	output logic                          done,
	output logic signed [SPEED_WIDTH-1:0] wheel_a_speed,
	output logic signed [SPEED_WIDTH-1:0] wheel_b_speed,
	output logic signed [SPEED_WIDTH-1:0] wheel_c_speed,
	output logic signed [SPEED_WIDTH-1:0] wheel_d_speed,
	output logic                          saturated
);

	cfg_t cfg_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= 1'b0;
			cfg_q.radius <= 12'd300;
			cfg_q.arm    <= 16'd4096;
			cfg_q.scale  <= 32'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BASE_MODE: cfg_q.mode   <= cfg_data[0];
				REG_RADIUS:    cfg_q.radius <= cfg_data[11:0];
				REG_ARM:       cfg_q.arm    <= cfg_data[15:0];
				REG_SCALE:     cfg_q.scale  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: trig, with command delayed alongside
	logic                vld_s1;
	logic signed [15:0]  c0_s1, s0_s1, c30_s1, s30_s1, c60_s1, s60_s1;
	logic signed [15:0]  vx_s1, vy_s1, w_s1;

	ocws_trig u_trig (
		.clk(clk), .arst_n(arst_n), .vld_in(start), .heading(heading),
		.vld_s1(vld_s1), .cos0_s1(c0_s1), .sin0_s1(s0_s1),
		.cos30_s1(c30_s1), .sin30_s1(s30_s1), .cos60_s1(c60_s1), .sin60_s1(s60_s1)
	);

	always_ff @(posedge clk) begin
		vx_s1 <= vel_x;
		vy_s1 <= vel_y;
		w_s1  <= omega;
	end

	// stage 2: the 16x16 trig products in q14, and the radius and arm products with omega
	logic               vld_s2;
	logic signed [31:0] p_c0x_s2, p_s0y_s2, p_s0x_s2, p_c0y_s2;
	logic signed [31:0] p_s30x_s2, p_c30y_s2, p_c60x_s2, p_s60y_s2;
	logic signed [31:0] rw_s2;
	logic signed [32:0] kw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		p_c0x_s2  <= c0_s1 * vx_s1;
		p_s0y_s2  <= s0_s1 * vy_s1;
		p_s0x_s2  <= s0_s1 * vx_s1;
		p_c0y_s2  <= c0_s1 * vy_s1;
		p_s30x_s2 <= s30_s1 * vx_s1;
		p_c30y_s2 <= c30_s1 * vy_s1;
		p_c60x_s2 <= c60_s1 * vx_s1;
		p_s60y_s2 <= s60_s1 * vy_s1;
		rw_s2     <= $signed({1'b0, cfg_q.radius}) * w_s1;
		kw_s2     <= $signed({1'b0, cfg_q.arm}) * w_s1;
	end

	// stage 3: wheel sums in q18
	logic               vld_s3;
	logic signed [39:0] va_s3, vb_s3, vc_s3, vd_s3;
	logic signed [39:0] bx, by, rw, kk;

	always_comb begin
		bx = 40'(p_c0x_s2) + 40'(p_s0y_s2);
		by = 40'(p_c0y_s2) - 40'(p_s0x_s2);
		rw = 40'(rw_s2) <<< 8;
		kk = 40'(kw_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (!cfg_q.mode) begin
			va_s3 <= (bx <<< 4) - rw;
			vb_s3 <= -(((40'(p_s30x_s2) - 40'(p_c30y_s2)) <<< 4) + rw);
			vc_s3 <= -(((40'(p_c60x_s2) + 40'(p_s60y_s2)) <<< 4) + rw);
			vd_s3 <= '0;
		end else begin
			va_s3 <= ((by + bx) <<< 4) - kk;
			vb_s3 <= ((by - bx) <<< 4) - kk;
			vc_s3 <= ((by + bx) <<< 4) + kk;
			vd_s3 <= ((by - bx) <<< 4) + kk;
		end
	end

	// stages 4 and 5: pulse conversion per wheel
	logic [3:0] sat_w;
	logic       vld_s4, vld_s5;

	ocws_pulse #(.SPEED_WIDTH(SPEED_WIDTH)) u_pa (
		.clk(clk), .vel(va_s3), .scale(cfg_q.scale), .speed(wheel_a_speed), .sat(sat_w[0]));
	ocws_pulse #(.SPEED_WIDTH(SPEED_WIDTH)) u_pb (
		.clk(clk), .vel(vb_s3), .scale(cfg_q.scale), .speed(wheel_b_speed), .sat(sat_w[1]));
	ocws_pulse #(.SPEED_WIDTH(SPEED_WIDTH)) u_pc (
		.clk(clk), .vel(vc_s3), .scale(cfg_q.scale), .speed(wheel_c_speed), .sat(sat_w[2]));
	ocws_pulse #(.SPEED_WIDTH(SPEED_WIDTH)) u_pd (
		.clk(clk), .vel(vd_s3), .scale(cfg_q.scale), .speed(wheel_d_speed), .sat(sat_w[3]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign done = vld_s5;
	assign saturated = |sat_w;

	// every command yields a result, and every result traces back to a command
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done) else $error("result missing");
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1, 4)) else $error("unexpected result");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !saturated) |-> !(sat_w[0] || sat_w[3])) else $error("flag mismatch");

endmodule

### verif/ocws_checker.sv
// ocws_checker: watches the command, config and result channels of the wheel speed block,
// predicts each result from its own copy of the registers and compares field by field
// depends on ocws_pkg for the register indexes and the quarter-wave sine table
`timescale 1ns / 1ps

module ocws_checker import ocws_pkg::*; #(
	parameter int SW = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic signed [15:0]   vel_x,
	input  logic signed [15:0]   vel_y,
	input  logic signed [15:0]   omega,
	input  logic [15:0]          heading,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 done,
	input  logic signed [SW-1:0] wheel_a_speed,
	input  logic signed [SW-1:0] wheel_b_speed,
	input  logic signed [SW-1:0] wheel_c_speed,
	input  logic signed [SW-1:0] wheel_d_speed,
	input  logic                 saturated,
	output int                   fail_count,
	output int                   outstanding
);

	typedef struct {
		logic signed [SW-1:0] wa;
		logic signed [SW-1:0] wb;
		logic signed [SW-1:0] wc;
		logic signed [SW-1:0] wd;
		logic                 sat;
	} wheel_set_t;

	wheel_set_t  speeds_q[$];
	logic        mode_r;
	logic [11:0] radius_r;
	logic [15:0] arm_r;
	logic [31:0] scale_r;

	assign outstanding = speeds_q.size();

	function automatic longint sin14(input logic [15:0] a);
		int p, i, f, v, t0, t1;
		p = a[14] ? 16384 - int'(a[13:0]) : int'(a[13:0]);
		i = p >> 8;
		f = p & 255;
		if (i >= 64) begin
			v = 16384;
		end else begin
			t0 = QUARTER_SINE[i];
			t1 = QUARTER_SINE[i + 1];
			v = t0 + (((t1 - t0) * f + 128) >>> 8);
		end
		return a[15] ? -longint'(v) : longint'(v);
	endfunction

	function automatic longint cos14(input logic [15:0] a);
		return sin14(a + 16'd16384);
	endfunction

	// q18 velocity times q16.16 scale, truncated toward zero, then clamped
	function automatic logic signed [SW-1:0] pulses(input longint v, inout logic sat);
		logic [63:0] mag, m, maxpos;
		logic        neg;
		neg = v < 0;
		mag = neg ? 64'(-v) : 64'(v);
		m = (mag * scale_r[31:16] + ((mag * scale_r[15:0]) >> 16)) >> 18;
		maxpos = (64'd1 << (SW - 1)) - 1;
		if (!neg && m > maxpos) begin
			m = maxpos;
			sat = 1'b1;
		end else if (neg && m > maxpos + 1) begin
			m = maxpos + 1;
			sat = 1'b1;
		end
		m = neg ? -m : m;
		return m[SW-1:0];
	endfunction

	function automatic wheel_set_t predict_speeds(input logic signed [15:0] vx_i,
			input logic signed [15:0] vy_i, input logic signed [15:0] w_i,
			input logic [15:0] h);
		wheel_set_t r;
		longint vx, vy, w, rw, c, s, bx, by, k;
		logic   sat;
		vx = vx_i;
		vy = vy_i;
		w = w_i;
		sat = 1'b0;
		if (!mode_r) begin
			rw = longint'(radius_r) * w * 256;
			r.wa = pulses((cos14(h) * vx + sin14(h) * vy) * 16 - rw, sat);
			r.wb = pulses(-((sin14(h + ANG30) * vx - cos14(h + ANG30) * vy) * 16 + rw), sat);
			r.wc = pulses(-((cos14(h + ANG60) * vx + sin14(h + ANG60) * vy) * 16 + rw), sat);
			r.wd = '0;
		end else begin
			c = cos14(h);
			s = sin14(h);
			bx = vx * c + vy * s;
			by = -vx * s + vy * c;
			k = longint'(arm_r) * w;
			r.wa = pulses((by + bx) * 16 - k, sat);
			r.wb = pulses((by - bx) * 16 - k, sat);
			r.wc = pulses((by + bx) * 16 + k, sat);
			r.wd = pulses((by - bx) * 16 + k, sat);
		end
		r.sat = sat;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		wheel_set_t e;
		if (!arst_n) begin
			mode_r <= 1'b0;
			radius_r <= 12'd300;
			arm_r <= 16'd4096;
			scale_r <= 32'd65536;
		end else begin
			if (start && !busy)
				speeds_q.push_back(predict_speeds(vel_x, vel_y, omega, heading));
			if (done) begin
				if (speeds_q.size() == 0) begin
					report_mismatch("unexpected result", 0, 0);
				end else begin
					e = speeds_q.pop_front();
					if (wheel_a_speed !== e.wa) report_mismatch("wheel_a", wheel_a_speed, e.wa);
					if (wheel_b_speed !== e.wb) report_mismatch("wheel_b", wheel_b_speed, e.wb);
					if (wheel_c_speed !== e.wc) report_mismatch("wheel_c", wheel_c_speed, e.wc);
					if (wheel_d_speed !== e.wd) report_mismatch("wheel_d", wheel_d_speed, e.wd);
					if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASE_MODE: mode_r <= cfg_data[0];
					REG_RADIUS:    radius_r <= cfg_data[11:0];
					REG_ARM:       arm_r <= cfg_data[15:0];
					REG_SCALE:     scale_r <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	initial fail_count = 0;

endmodule

### verif/omni_chassis_wheel_speeds_tb.sv
// omni_chassis_wheel_speeds_tb: drives commands and register writes into the wheel speed
// block and gives the verdict from the failure count of ocws_checker
// depends on ocws_pkg, omni_chassis_wheel_speeds and ocws_checker
`timescale 1ns / 1ps

module omni_chassis_wheel_speeds_tb;
	import ocws_pkg::*;

	localparam int SW = 25;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic signed [15:0]   vel_x;
	logic signed [15:0]   vel_y;
	logic signed [15:0]   omega;
	logic [15:0]          heading;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [1:0]           cfg_index;
	logic [31:0]          cfg_data;
	logic                 done;
	logic signed [SW-1:0] wheel_a_speed;
	logic signed [SW-1:0] wheel_b_speed;
	logic signed [SW-1:0] wheel_c_speed;
	logic signed [SW-1:0] wheel_d_speed;
	logic                 saturated;
	int                   fail_count;
	int                   outstanding;

	omni_chassis_wheel_speeds #(.SPEED_WIDTH(SW)) u_top (.*);

	ocws_checker #(.SW(SW)) u_checker (.*);

	// free running clock, 10 ns period
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

	// one command item; start stays high across back-to-back items
	task automatic send_cmd(input logic [15:0] vx, input logic [15:0] vy,
			input logic [15:0] w, input logic [15:0] h);
		logic b;
		@(negedge clk);
		start = 1'b1;
		vel_x = vx;
		vel_y = vy;
		omega = w;
		heading = h;
		forever begin
			b = busy;
			@(posedge clk);
			if (!b) break;
			@(negedge clk);
		end
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// drain the pipeline; items never vanish, but give the latency some slack anyway
	task automatic wait_idle();
		idle_cycles(1);
		wait (outstanding == 0);
		idle_cycles(16);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		logic r;
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		forever begin
			r = cfg_ready;
			@(posedge clk);
			if (r) break;
			@(negedge clk);
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// junk in the upper bits of the narrow registers must be dropped
	task automatic load_setting(input logic mode, input logic [11:0] radius,
			input logic [15:0] arm, input logic [31:0] scale);
		wait_idle();
		write_reg(REG_BASE_MODE, {$urandom} & 32'hFFFF_FFFE | mode);
		write_reg(REG_RADIUS, {$urandom} & 32'hFFFF_F000 | radius);
		write_reg(REG_ARM, {$urandom} & 32'hFFFF_0000 | arm);
		write_reg(REG_SCALE, scale);
	endtask

	// field value biased toward the edges of the signed range
	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 200)) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return 32'($urandom);
			1: return 32'($urandom_range(0, 255));
			default: return 32'($urandom_range(0, 32'h3FFFF));
		endcase
	endfunction

	initial begin
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		vel_x = '0;
		vel_y = '0;
		omega = '0;
		heading = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, three-wheel base
		send_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
		send_cmd(16'h8000, 16'h8000, 16'h8000, 16'h4000);
		send_cmd(16'h7FFF, 16'h8000, 16'h0000, 16'h8000);
		send_cmd(16'h8000, 16'h7FFF, 16'h7FFF, 16'hC000);
		send_cmd(16'h1234, 16'hF000, 16'h0400, 16'hFFFF);
		send_cmd(16'h0100, 16'h0100, 16'hFC00, 16'h3FFF);

		// directed: four-wheel base, largest arm
		load_setting(1'b1, 12'd300, 16'hFFFF, 32'd65536);
		send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000);
		send_cmd(16'h8000, 16'h8000, 16'h8000, 16'hE000);
		send_cmd(16'h7FFF, 16'h8000, 16'h8000, 16'h4000);
		send_cmd(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);

		// directed: largest scale forces clamping in both directions
		load_setting(1'b0, 12'hFFF, 16'd0, 32'hFFFF_FFFF);
		send_cmd(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000);
		send_cmd(16'h8000, 16'h8000, 16'h7FFF, 16'h9000);
		send_cmd(16'h0001, 16'h0000, 16'h0000, 16'h0000);

		// directed: zero scale gives all-zero speeds
		load_setting(1'b1, 12'd0, 16'hFFFF, 32'd0);
		send_cmd(16'h7FFF, 16'h8000, 16'h7FFF, 16'h1000);
		send_cmd(16'h8000, 16'h7FFF, 16'h8000, 16'h5000);

		// random phases, several register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_setting(1'b0, 12'd300, 16'd4096, 32'd65536);
				1: load_setting(1'b1, 12'($urandom), 16'($urandom), pick_scale());
				2: load_setting(1'b0, 12'hFFF, 16'($urandom), 32'hFFFF_FFFF);
				3: load_setting(1'b1, 12'($urandom), 16'hFFFF, pick_scale());
				4: load_setting(1'b0, 12'd0, 16'd0, pick_scale());
				5: load_setting(1'b1, 12'd0, 16'd0, 32'hFFFF_FFFF);
				default: load_setting(1'($urandom), 12'($urandom), 16'($urandom), pick_scale());
			endcase
			n = 0;
			while (n < 112) begin
				// burst of back-to-back items, then a gap; sometimes no gap at all
				repeat ($urandom_range(1, 20)) begin
					send_cmd(pick16(), pick16(), pick16(), 16'($urandom));
					n++;
				end
				if ($urandom_range(0, 3) != 0)
					idle_cycles($urandom_range(1, 6));
			end
		end

		idle_cycles(1);
		wait (outstanding == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### sim.f
src/ocws_pkg.sv
src/ocws_trig.sv
src/ocws_pulse.sv
src/omni_chassis_wheel_speeds.sv
verif/ocws_checker.sv
verif/omni_chassis_wheel_speeds_tb.sv
